@@ rtl/core/stereo_three_band_biquad_eq_defines.svh @@
// ============================================================================
// Stereo three-band equalizer assertion macros
// Shared property templates for the port-level checker.
// ============================================================================
`ifndef STEREO_THREE_BAND_BIQUAD_EQ_DEFINES_SVH
`define STEREO_THREE_BAND_BIQUAD_EQ_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define S3BEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("s3beq: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define S3BEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("s3beq: property failed");

// Next-cycle implication that is also checked during reset.
`define S3BEQ_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("s3beq: property failed");

`endif

@@ rtl/core/s3beq_pkg.sv @@
// ============================================================================
// Stereo three-band equalizer package
// Register map, MAC term codes and the sequencer-to-datapath control bundle.
// ============================================================================
package s3beq_pkg;

    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_SHIFT     = 3;
    localparam int MAX_BANDS     = 3;
    localparam int BAND_BITS     = 2;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 15;
    localparam int STEP_BITS     = 3;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'h8000;
    localparam logic [STEP_BITS-1:0] LAST_STEP  = 3'd4;

    typedef enum logic [2:0] {
        REG_LOW_NUM  = 3'd0,
        REG_LOW_DEN  = 3'd1,
        REG_MID_NUM  = 3'd2,
        REG_MID_DEN  = 3'd3,
        REG_HIGH_NUM = 3'd4,
        REG_HIGH_DEN = 3'd5,
        REG_GAIN     = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        TERM_B1   = 3'd0,
        TERM_B2   = 3'd1,
        TERM_A1   = 3'd2,
        TERM_A2   = 3'd3,
        TERM_B0   = 3'd4,
        TERM_GAIN = 3'd5
    } t_term;

    typedef struct packed {
        logic                 start;
        logic                 mac;
        logic                 init;
        t_term                term;
        logic                 fin;
        logic                 gain;
        logic                 ch;
        logic [BAND_BITS-1:0] band;
        logic                 rd;
        logic                 rd_ch;
        logic [BAND_BITS-1:0] rd_band;
        logic                 out_load;
    } t_ctl;

endpackage

@@ rtl/core/stereo_three_band_biquad_eq.sv @@
// ============================================================================
// Stereo three-band biquad equalizer
// Low shelf, mid peak and high shelf biquads per channel, then volume gain.
// ============================================================================
// A stereo frame is one transfer on the input channel (i_valid / o_ready) and
// gives one transfer on the output channel (o_valid / i_ready).
// Coefficients and gain sit in an APB-style register file, 64-bit registers
// at byte address 8*i, and are to be written only while the block is idle;
// the block itself does not enforce this.
// One multiplier serves every product: per channel each band multiplies its
// five terms (b1, b2, a1, a2, b0) and rounds, and the gain multiplies once and
// rounds. A new frame is taken only after the previous result has been loaded
// into the output register.
// Filter history lives in a small synchronous memory with one row per band and
// channel; a frame with the restart bit set sees all history as zero.
// Reset loads the default registers (unity filters and gain), empties the
// history and the output register; no clearing pass is needed.
// A finished frame waits in the output register while the receiver stalls,
// and the next frame may be accepted and processed meanwhile; its result is
// held back until the output register is free.
module stereo_three_band_biquad_eq #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 20,
    parameter int NUM_BANDS   = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_in,
    input  logic                                  i_restart,
    input  logic                                  i_end_of_block,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_left_eq,
    output logic signed [SAMPLE_BITS-1:0]         o_right_eq,
    output logic                                  o_clipped,
    output logic                                  o_end_of_block_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [s3beq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [s3beq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [s3beq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                  pready
);

    logic [s3beq_pkg::MAX_BANDS-1:0][3*COEF_BITS-1:0] w_num;
    logic [s3beq_pkg::MAX_BANDS-1:0][2*COEF_BITS-1:0] w_den;
    logic [s3beq_pkg::GAIN_BITS-1:0]                  w_gain;
    s3beq_pkg::t_ctl                                  w_ctl;

    s3beq_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_gain  (w_gain)
    );

    s3beq_seq #(
        .NUM_BANDS (NUM_BANDS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (w_ctl)
    );

    s3beq_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .NUM_BANDS   (NUM_BANDS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (w_ctl),
        .i_num              (w_num),
        .i_den              (w_den),
        .i_gain             (w_gain),
        .i_left_in          (i_left_in),
        .i_right_in         (i_right_in),
        .i_restart          (i_restart),
        .i_end_of_block     (i_end_of_block),
        .o_left_eq          (o_left_eq),
        .o_right_eq         (o_right_eq),
        .o_clipped          (o_clipped),
        .o_end_of_block_out (o_end_of_block_out)
    );

endmodule

@@ rtl/core/s3beq_regs.sv @@
// ============================================================================
// Equalizer configuration registers
// APB-style register file holding the biquad coefficients and the volume gain.
// ============================================================================
module s3beq_regs #(
    parameter int COEF_BITS = 20
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  psel,
    input  logic                                                  penable,
    input  logic                                                  pwrite,
    input  logic [s3beq_pkg::APB_ADDR_BITS-1:0]                   paddr,
    input  logic [s3beq_pkg::APB_DATA_BITS-1:0]                   pwdata,
    output logic [s3beq_pkg::APB_DATA_BITS-1:0]                   prdata,
    output logic                                                  pready,
    output logic [s3beq_pkg::MAX_BANDS-1:0][3*COEF_BITS-1:0]      o_num,
    output logic [s3beq_pkg::MAX_BANDS-1:0][2*COEF_BITS-1:0]      o_den,
    output logic [s3beq_pkg::GAIN_BITS-1:0]                       o_gain
);

    localparam int NUM_W = 3 * COEF_BITS;
    localparam int DEN_W = 2 * COEF_BITS;
    localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1) << (COEF_BITS - 3);

    logic [s3beq_pkg::MAX_BANDS-1:0][NUM_W-1:0] r_num;
    logic [s3beq_pkg::MAX_BANDS-1:0][DEN_W-1:0] r_den;
    logic [s3beq_pkg::GAIN_BITS-1:0]            r_gain;
    s3beq_pkg::t_reg_idx                        w_idx;
    logic                                       w_wr;

    assign w_idx  = s3beq_pkg::t_reg_idx'(paddr[s3beq_pkg::APB_ADDR_BITS-1:s3beq_pkg::REG_SHIFT]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= {s3beq_pkg::MAX_BANDS{NUM_RESET}};
            r_den  <= '0;
            r_gain <= s3beq_pkg::GAIN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                s3beq_pkg::REG_LOW_NUM:  r_num[0] <= pwdata[NUM_W-1:0];
                s3beq_pkg::REG_LOW_DEN:  r_den[0] <= pwdata[DEN_W-1:0];
                s3beq_pkg::REG_MID_NUM:  r_num[1] <= pwdata[NUM_W-1:0];
                s3beq_pkg::REG_MID_DEN:  r_den[1] <= pwdata[DEN_W-1:0];
                s3beq_pkg::REG_HIGH_NUM: r_num[2] <= pwdata[NUM_W-1:0];
                s3beq_pkg::REG_HIGH_DEN: r_den[2] <= pwdata[DEN_W-1:0];
                s3beq_pkg::REG_GAIN:     r_gain   <= pwdata[s3beq_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            s3beq_pkg::REG_LOW_NUM:  prdata = s3beq_pkg::APB_DATA_BITS'(r_num[0]);
            s3beq_pkg::REG_LOW_DEN:  prdata = s3beq_pkg::APB_DATA_BITS'(r_den[0]);
            s3beq_pkg::REG_MID_NUM:  prdata = s3beq_pkg::APB_DATA_BITS'(r_num[1]);
            s3beq_pkg::REG_MID_DEN:  prdata = s3beq_pkg::APB_DATA_BITS'(r_den[1]);
            s3beq_pkg::REG_HIGH_NUM: prdata = s3beq_pkg::APB_DATA_BITS'(r_num[2]);
            s3beq_pkg::REG_HIGH_DEN: prdata = s3beq_pkg::APB_DATA_BITS'(r_den[2]);
            s3beq_pkg::REG_GAIN:     prdata = s3beq_pkg::APB_DATA_BITS'(r_gain);
            default:                 prdata = '0;
        endcase
    end

    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_gain = r_gain;

endmodule

@@ rtl/core/s3beq_seq.sv @@
// ============================================================================
// Equalizer sequencer
// Steps the shared MAC through every band and the gain stage of both channels.
// ============================================================================
module s3beq_seq #(
    parameter int NUM_BANDS = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output s3beq_pkg::t_ctl  o_ctl
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    localparam logic [s3beq_pkg::BAND_BITS-1:0] LAST_BAND =
        s3beq_pkg::BAND_BITS'(NUM_BANDS - 1);

    t_state                             r_state, n_state;
    logic [s3beq_pkg::STEP_BITS-1:0]    r_step, n_step;
    logic [s3beq_pkg::BAND_BITS-1:0]    r_band, n_band;
    logic                               r_ch, n_ch;
    logic                               r_gain, n_gain;
    logic                               r_out_valid, n_out_valid;
    s3beq_pkg::t_ctl                    w_ctl;

    function automatic s3beq_pkg::t_term step_term(input logic [s3beq_pkg::STEP_BITS-1:0] s);
        s3beq_pkg::t_term t;
        case (s)
            3'd0:    t = s3beq_pkg::TERM_B1;
            3'd1:    t = s3beq_pkg::TERM_B2;
            3'd2:    t = s3beq_pkg::TERM_A1;
            3'd3:    t = s3beq_pkg::TERM_A2;
            default: t = s3beq_pkg::TERM_B0;
        endcase
        return t;
    endfunction

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_band      = r_band;
        n_ch        = r_ch;
        n_gain      = r_gain;
        w_ctl       = '0;
        w_ctl.term  = s3beq_pkg::TERM_B0;
        w_ctl.ch    = r_ch;
        w_ctl.band  = r_band;
        w_ctl.gain  = r_gain;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_ctl.start   = 1'b1;
                    w_ctl.rd      = 1'b1;
                    w_ctl.rd_band = '0;
                    w_ctl.rd_ch   = 1'b0;
                    n_band        = '0;
                    n_ch          = 1'b0;
                    n_gain        = 1'b0;
                    n_step        = '0;
                    n_state       = ST_MAC;
                end
            end
            ST_MAC: begin
                w_ctl.mac  = 1'b1;
                w_ctl.init = (r_step == '0);
                w_ctl.term = r_gain ? s3beq_pkg::TERM_GAIN : step_term(r_step);
                if (r_gain || (r_step == s3beq_pkg::LAST_STEP)) begin
                    n_state = ST_ROUND;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_ROUND: begin
                w_ctl.fin = 1'b1;
                n_step    = '0;
                n_state   = ST_MAC;
                if (r_gain) begin
                    if (!r_ch) begin
                        n_ch          = 1'b1;
                        n_band        = '0;
                        n_gain        = 1'b0;
                        w_ctl.rd      = 1'b1;
                        w_ctl.rd_band = '0;
                        w_ctl.rd_ch   = 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else if (r_band == LAST_BAND) begin
                    n_gain = 1'b1;
                end else begin
                    n_band        = r_band + 1'b1;
                    w_ctl.rd      = 1'b1;
                    w_ctl.rd_band = r_band + 1'b1;
                    w_ctl.rd_ch   = r_ch;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    w_ctl.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_band      <= '0;
            r_ch        <= 1'b0;
            r_gain      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_band      <= n_band;
            r_ch        <= n_ch;
            r_gain      <= n_gain;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_ctl   = w_ctl;

endmodule

@@ rtl/core/s3beq_dp.sv @@
// ============================================================================
// Equalizer datapath
// History memory, shared multiply-accumulate unit, rounding and saturation.
// ============================================================================
module s3beq_dp #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 20,
    parameter int NUM_BANDS   = 3
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  s3beq_pkg::t_ctl                                   i_ctl,
    input  logic [s3beq_pkg::MAX_BANDS-1:0][3*COEF_BITS-1:0]  i_num,
    input  logic [s3beq_pkg::MAX_BANDS-1:0][2*COEF_BITS-1:0]  i_den,
    input  logic [s3beq_pkg::GAIN_BITS-1:0]                   i_gain,
    input  logic signed [SAMPLE_BITS-1:0]                     i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]                     i_right_in,
    input  logic                                              i_restart,
    input  logic                                              i_end_of_block,
    output logic signed [SAMPLE_BITS-1:0]                     o_left_eq,
    output logic signed [SAMPLE_BITS-1:0]                     o_right_eq,
    output logic                                              o_clipped,
    output logic                                              o_end_of_block_out
);

    localparam int SW   = SAMPLE_BITS;
    localparam int CW   = COEF_BITS;
    localparam int MW   = (CW > s3beq_pkg::GAIN_BITS) ? CW : s3beq_pkg::GAIN_BITS + 1;
    localparam int PW   = SW + MW;
    localparam int AW   = PW + 3;
    localparam int CF   = CW - 3;
    localparam int ROWS = 2 * NUM_BANDS;
    localparam int RAW  = $clog2(ROWS);
    localparam int RW   = 4 * SW;
    localparam int SELW = s3beq_pkg::BAND_BITS + 1;
    localparam logic signed [AW-1:0] BAND_HALF = AW'(1) << (CF - 1);
    localparam logic signed [AW-1:0] GAIN_HALF = AW'(1) << (s3beq_pkg::GAIN_FRAC - 1);
    localparam logic signed [SW-1:0] SAT_HI    = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO    = {1'b1, {(SW - 1){1'b0}}};

    logic [RW-1:0]              r_mem [ROWS];
    logic [RW-1:0]              r_rd;
    logic                       r_rd_ok;
    logic [ROWS-1:0]            r_row_valid;
    logic signed [PW-1:0]       r_prod;
    logic                       r_prod_sub;
    logic signed [AW-1:0]       r_acc;
    logic signed [SW-1:0]       r_v;
    logic signed [SW-1:0]       r_right;
    logic signed [SW-1:0]       r_res_left;
    logic signed [SW-1:0]       r_res_right;
    logic                       r_clip;
    logic                       r_eob;
    logic signed [SW-1:0]       r_o_left;
    logic signed [SW-1:0]       r_o_right;
    logic                       r_o_clip;
    logic                       r_o_eob;

    logic [SELW-1:0]            w_rd_sel;
    logic [SELW-1:0]            w_wr_sel;
    logic [RAW-1:0]             w_rd_row;
    logic [RAW-1:0]             w_wr_row;
    logic                       w_wr;
    logic                       w_clear;
    logic [RW-1:0]              w_hist;
    logic signed [SW-1:0]       w_x1;
    logic signed [SW-1:0]       w_x2;
    logic signed [SW-1:0]       w_y1;
    logic signed [SW-1:0]       w_y2;
    logic [3*CW-1:0]            w_num;
    logic [2*CW-1:0]            w_den;
    logic signed [MW-1:0]       w_op_a;
    logic signed [SW-1:0]       w_op_x;
    logic                       w_sub;
    logic signed [PW-1:0]       w_prod;
    logic signed [AW-1:0]       w_acc_sum;
    logic signed [AW-1:0]       w_shift;
    logic [AW-SW:0]             w_top;
    logic                       w_ovf;
    logic signed [SW-1:0]       w_y;
    logic [RW-1:0]              w_new_row;

    assign w_rd_sel = {i_ctl.rd_band, i_ctl.rd_ch};
    assign w_wr_sel = {i_ctl.band, i_ctl.ch};
    assign w_rd_row = w_rd_sel[RAW-1:0];
    assign w_wr_row = w_wr_sel[RAW-1:0];
    assign w_wr     = i_ctl.fin && !i_ctl.gain;
    assign w_clear  = i_ctl.start && i_restart;

    // Rows that were never written since reset or the last restart read as zero.
    assign w_hist = r_rd_ok ? r_rd : '0;
    assign w_x1   = w_hist[SW-1:0];
    assign w_x2   = w_hist[2*SW-1:SW];
    assign w_y1   = w_hist[3*SW-1:2*SW];
    assign w_y2   = w_hist[4*SW-1:3*SW];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_wr_row] <= w_new_row;
        end
        if (i_ctl.rd) begin
            r_rd <= r_mem[w_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (w_clear) begin
                r_row_valid <= '0;
            end else if (w_wr) begin
                r_row_valid[w_wr_row] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_ok <= r_row_valid[w_rd_row] && !w_clear;
            end
        end
    end

    assign w_num = i_num[i_ctl.band];
    assign w_den = i_den[i_ctl.band];

    always_comb begin
        case (i_ctl.term)
            s3beq_pkg::TERM_B1: begin
                w_op_a = MW'($signed(w_num[2*CW-1:CW]));
                w_op_x = w_x1;
            end
            s3beq_pkg::TERM_B2: begin
                w_op_a = MW'($signed(w_num[3*CW-1:2*CW]));
                w_op_x = w_x2;
            end
            s3beq_pkg::TERM_A1: begin
                w_op_a = MW'($signed(w_den[CW-1:0]));
                w_op_x = w_y1;
            end
            s3beq_pkg::TERM_A2: begin
                w_op_a = MW'($signed(w_den[2*CW-1:CW]));
                w_op_x = w_y2;
            end
            s3beq_pkg::TERM_GAIN: begin
                w_op_a = MW'($signed({1'b0, i_gain}));
                w_op_x = r_v;
            end
            default: begin
                w_op_a = MW'($signed(w_num[CW-1:0]));
                w_op_x = r_v;
            end
        endcase
    end

    assign w_sub  = (i_ctl.term == s3beq_pkg::TERM_A1) || (i_ctl.term == s3beq_pkg::TERM_A2);
    assign w_prod = w_op_a * w_op_x;

    assign w_acc_sum = r_prod_sub ? (r_acc - AW'(r_prod)) : (r_acc + AW'(r_prod));
    assign w_shift   = i_ctl.gain ? (w_acc_sum >>> s3beq_pkg::GAIN_FRAC) : (w_acc_sum >>> CF);
    assign w_top     = w_shift[AW-1:SW-1];
    assign w_ovf     = !((&w_top) || !(|w_top));
    assign w_y       = w_ovf ? (w_shift[AW-1] ? SAT_LO : SAT_HI) : w_shift[SW-1:0];
    assign w_new_row = {w_y1, w_y, w_x1, r_v};

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac) begin
            r_prod     <= w_prod;
            r_prod_sub <= w_sub;
            r_acc      <= i_ctl.init ? (i_ctl.gain ? GAIN_HALF : BAND_HALF) : w_acc_sum;
        end
        if (i_ctl.start) begin
            r_v     <= i_left_in;
            r_right <= i_right_in;
            r_eob   <= i_end_of_block;
            r_clip  <= 1'b0;
        end else if (i_ctl.fin) begin
            r_clip <= r_clip || w_ovf;
            if (!i_ctl.gain) begin
                r_v <= w_y;
            end else if (!i_ctl.ch) begin
                r_res_left <= w_y;
                r_v        <= r_right;
            end else begin
                r_res_right <= w_y;
            end
        end
        if (i_ctl.out_load) begin
            r_o_left  <= r_res_left;
            r_o_right <= r_res_right;
            r_o_clip  <= r_clip;
            r_o_eob   <= r_eob;
        end
    end

    assign o_left_eq          = r_o_left;
    assign o_right_eq         = r_o_right;
    assign o_clipped          = r_o_clip;
    assign o_end_of_block_out = r_o_eob;

endmodule

@@ rtl/core/s3beq_chk.sv @@
// ============================================================================
// Equalizer port checker
// Watches the frame channels of the top level and is bound to it.
// ============================================================================
`include "stereo_three_band_biquad_eq_defines.svh"

module s3beq_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] o_left_eq,
    input logic signed [SAMPLE_BITS-1:0] o_right_eq
);

    // A frame transfer starts the computation, so the block is busy right after it.
    `S3BEQ_ASSERT_NEXT(a_busy_after_input, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // A new result is loaded only as the block returns to accepting frames.
    `S3BEQ_ASSERT_NOW(a_result_with_ready, i_clk, i_rst_n, $rose(o_valid), o_ready)

    // A stalled result stays offered and unchanged.
    `S3BEQ_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_left_eq) && $stable(o_right_eq))

    // Reset empties the output register and leaves the block ready for a frame.
    `S3BEQ_ASSERT_ALWAYS_NEXT(a_reset_state, i_clk, !i_rst_n, !o_valid && o_ready)

endmodule

bind stereo_three_band_biquad_eq s3beq_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_s3beq_chk (.*);
